>>> rtl/cau_pkg.sv
// Shared widths, mode codes, side-band struct and saturation helpers of the complex ALU.
package cau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SAT_W     = PROD_W + 2;
	localparam int MAG_W     = PROD_W;
	localparam int NUM_W     = MAG_W + FRAC_BITS;
	localparam int Q_W       = DATA_W + 1;
	localparam int DSH_W     = MAG_W + Q_W - 1;
	localparam int OVF_W     = MAG_W + Q_W;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_NEG = 3'd4;

	typedef struct packed {
		logic                     is_div;
		logic                     dz;
		logic                     eq;
		logic                     ovf_re;
		logic                     ovf_im;
		logic                     neg_re;
		logic                     neg_im;
		logic signed [DATA_W-1:0] res_re;
		logic signed [DATA_W-1:0] res_im;
	} side_t;

	// Clamp a wide signed value into the 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-DATA_W:0] top;
		logic signed [DATA_W-1:0] r;
		top = v[SAT_W-1:DATA_W-1];
		if (top == '0 || top == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Apply sign to a quotient magnitude and clamp.
	function automatic logic signed [DATA_W-1:0] div_out(input logic neg, input logic ovf,
			input logic [Q_W-1:0] q);
		logic signed [DATA_W-1:0] r;
		logic [Q_W-1:0] lim_pos;
		logic [Q_W-1:0] lim_neg;
		lim_pos = {2'b00, {(DATA_W-1){1'b1}}};
		lim_neg = {2'b01, {(DATA_W-1){1'b0}}};
		if (!neg) begin
			r = (ovf || q > lim_pos) ? {1'b0, {(DATA_W-1){1'b1}}} : q[DATA_W-1:0];
		end else begin
			r = (ovf || q > lim_neg) ? {1'b1, {(DATA_W-1){1'b0}}} : -q[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/cau_front.sv
// Front stages: partial products, then sums, sign/magnitude and the non-divide results.
module cau_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_v,
	input  logic [2:0]                       mode,
	input  logic signed [cau_pkg::DATA_W-1:0] a_re,
	input  logic signed [cau_pkg::DATA_W-1:0] a_im,
	input  logic signed [cau_pkg::DATA_W-1:0] b_re,
	input  logic signed [cau_pkg::DATA_W-1:0] b_im,
	output logic                             v_s2,
	output cau_pkg::side_t                   side_s2,
	output logic [cau_pkg::MAG_W-1:0]        mag_re_s2,
	output logic [cau_pkg::MAG_W-1:0]        mag_im_s2,
	output logic [cau_pkg::MAG_W-1:0]        d_s2
);
	import cau_pkg::*;

	logic                     v_s1;
	logic signed [PROD_W-1:0] arbr_s1, aibi_s1, arbi_s1, aibr_s1, brbr_s1, bibi_s1;
	logic [2:0]               mode_s1;
	logic                     eq_s1;
	logic signed [DATA_W-1:0] lin_re_s1, lin_im_s1;

	logic signed [DATA_W-1:0] lin_re, lin_im;
	logic signed [SAT_W-1:0]  sum_re, sum_im, sh_re, sh_im;
	logic [MAG_W-1:0]         d_sum;
	logic                     is_div;
	side_t                    side_d;

	always_comb begin
		case (mode)
			MODE_ADD: begin
				lin_re = sat_data(SAT_W'(a_re) + SAT_W'(b_re));
				lin_im = sat_data(SAT_W'(a_im) + SAT_W'(b_im));
			end
			MODE_SUB: begin
				lin_re = sat_data(SAT_W'(a_re) - SAT_W'(b_re));
				lin_im = sat_data(SAT_W'(a_im) - SAT_W'(b_im));
			end
			MODE_NEG: begin
				lin_re = sat_data(-SAT_W'(a_re));
				lin_im = sat_data(-SAT_W'(a_im));
			end
			default: begin
				lin_re = '0;
				lin_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			arbr_s1   <= a_re * b_re;
			aibi_s1   <= a_im * b_im;
			arbi_s1   <= a_re * b_im;
			aibr_s1   <= a_im * b_re;
			brbr_s1   <= b_re * b_re;
			bibi_s1   <= b_im * b_im;
			mode_s1   <= mode;
			eq_s1     <= (a_re == b_re) && (a_im == b_im);
			lin_re_s1 <= lin_re;
			lin_im_s1 <= lin_im;
		end
	end

	always_comb begin
		is_div = (mode_s1 == MODE_DIV);
		if (is_div) begin
			sum_re = SAT_W'(arbr_s1) + SAT_W'(aibi_s1);
			sum_im = SAT_W'(aibr_s1) - SAT_W'(arbi_s1);
		end else begin
			sum_re = SAT_W'(arbr_s1) - SAT_W'(aibi_s1);
			sum_im = SAT_W'(arbi_s1) + SAT_W'(aibr_s1);
		end
		sh_re = sum_re >>> FRAC_BITS;
		sh_im = sum_im >>> FRAC_BITS;
		d_sum = MAG_W'(brbr_s1) + MAG_W'(bibi_s1);

		side_d.is_div = is_div;
		side_d.dz     = is_div && (d_sum == '0);
		side_d.eq     = eq_s1;
		side_d.ovf_re = 1'b0;
		side_d.ovf_im = 1'b0;
		side_d.neg_re = sum_re[SAT_W-1];
		side_d.neg_im = sum_im[SAT_W-1];
		case (mode_s1)
			MODE_ADD, MODE_SUB, MODE_NEG: begin
				side_d.res_re = lin_re_s1;
				side_d.res_im = lin_im_s1;
			end
			MODE_MUL: begin
				side_d.res_re = sat_data(sh_re);
				side_d.res_im = sat_data(sh_im);
			end
			default: begin
				side_d.res_re = '0;
				side_d.res_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2   <= side_d;
			mag_re_s2 <= sum_re[SAT_W-1] ? MAG_W'(-sum_re) : MAG_W'(sum_re);
			mag_im_s2 <= sum_im[SAT_W-1] ? MAG_W'(-sum_im) : MAG_W'(sum_im);
			d_s2      <= d_sum;
		end
	end

endmodule

>>> rtl/cau_div_step.sv
// One restoring-division stage: one quotient bit for both parts against a shared divisor.
module cau_div_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       v_in,
	input  cau_pkg::side_t             side_in,
	input  logic [cau_pkg::NUM_W-1:0]  rem_re_in,
	input  logic [cau_pkg::NUM_W-1:0]  rem_im_in,
	input  logic [cau_pkg::DSH_W-1:0]  dsh_in,
	input  logic [cau_pkg::Q_W-1:0]    q_re_in,
	input  logic [cau_pkg::Q_W-1:0]    q_im_in,
	output logic                       v_out,
	output cau_pkg::side_t             side_out,
	output logic [cau_pkg::NUM_W-1:0]  rem_re_out,
	output logic [cau_pkg::NUM_W-1:0]  rem_im_out,
	output logic [cau_pkg::DSH_W-1:0]  dsh_out,
	output logic [cau_pkg::Q_W-1:0]    q_re_out,
	output logic [cau_pkg::Q_W-1:0]    q_im_out
);
	import cau_pkg::*;

	logic ge_re, ge_im;

	assign ge_re = DSH_W'(rem_re_in) >= dsh_in;
	assign ge_im = DSH_W'(rem_im_in) >= dsh_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_out   <= side_in;
			rem_re_out <= ge_re ? rem_re_in - dsh_in[NUM_W-1:0] : rem_re_in;
			rem_im_out <= ge_im ? rem_im_in - dsh_in[NUM_W-1:0] : rem_im_in;
			dsh_out    <= dsh_in >> 1;
			q_re_out   <= {q_re_in[Q_W-2:0], ge_re};
			q_im_out   <= {q_im_in[Q_W-2:0], ge_im};
		end
	end

endmodule

>>> rtl/complex_arithmetic_unit.sv
// An accepted word passes the front stages, the setup stage, the divide stages and the output register.
// Throughput: one word per cycle while the output is not stalled; every mode takes the same path so order is kept.
// The 33 quotient-bit stages of the divider set the depth; the six 32x32 products set stage 1.
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
// operands_equal is reported in every mode; unused modes give a zero result.
module complex_arithmetic_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        mode,
	input  logic signed [cau_pkg::DATA_W-1:0] a_re,
	input  logic signed [cau_pkg::DATA_W-1:0] a_im,
	input  logic signed [cau_pkg::DATA_W-1:0] b_re,
	input  logic signed [cau_pkg::DATA_W-1:0] b_im,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cau_pkg::DATA_W-1:0] res_re,
	output logic signed [cau_pkg::DATA_W-1:0] res_im,
	output logic                              operands_equal,
	output logic                              divide_by_zero
);
	import cau_pkg::*;

	// Advance the whole pipe whenever the output slot is free or being taken.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	logic             v_s2;
	side_t            side_s2;
	logic [MAG_W-1:0] mag_re_s2, mag_im_s2, d_s2;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_v      (in_valid),
		.mode      (mode),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.v_s2      (v_s2),
		.side_s2   (side_s2),
		.mag_re_s2 (mag_re_s2),
		.mag_im_s2 (mag_im_s2),
		.d_s2      (d_s2)
	);

	// Divider chain; slot 0 is the setup stage (s3), slot Q_W is the last quotient bit.
	logic             v_c    [0:Q_W];
	side_t            side_c [0:Q_W];
	logic [NUM_W-1:0] rem_re_c [0:Q_W];
	logic [NUM_W-1:0] rem_im_c [0:Q_W];
	logic [DSH_W-1:0] dsh_c  [0:Q_W];
	logic [Q_W-1:0]   q_re_c [0:Q_W];
	logic [Q_W-1:0]   q_im_c [0:Q_W];

	// Quotient of (mag << FRAC_BITS) / d reaches 2^Q_W exactly when mag >= d << (Q_W - FRAC_BITS);
	// flag that up front so the chain only has to produce Q_W bits.
	side_t side_d;
	always_comb begin
		side_d        = side_s2;
		side_d.ovf_re = OVF_W'(mag_re_s2) >= (OVF_W'(d_s2) << (Q_W - FRAC_BITS));
		side_d.ovf_im = OVF_W'(mag_im_s2) >= (OVF_W'(d_s2) << (Q_W - FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (adv) begin
			v_c[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_c[0]   <= side_d;
			rem_re_c[0] <= NUM_W'(mag_re_s2) << FRAC_BITS;
			rem_im_c[0] <= NUM_W'(mag_im_s2) << FRAC_BITS;
			dsh_c[0]    <= DSH_W'(d_s2) << (Q_W - 1);
			q_re_c[0]   <= '0;
			q_im_c[0]   <= '0;
		end
	end

	genvar g;
	generate
		for (g = 0; g < Q_W; g++) begin : g_div
			cau_div_step u_step (
				.clk        (clk),
				.arst_n     (arst_n),
				.adv        (adv),
				.v_in       (v_c[g]),
				.side_in    (side_c[g]),
				.rem_re_in  (rem_re_c[g]),
				.rem_im_in  (rem_im_c[g]),
				.dsh_in     (dsh_c[g]),
				.q_re_in    (q_re_c[g]),
				.q_im_in    (q_im_c[g]),
				.v_out      (v_c[g+1]),
				.side_out   (side_c[g+1]),
				.rem_re_out (rem_re_c[g+1]),
				.rem_im_out (rem_im_c[g+1]),
				.dsh_out    (dsh_c[g+1]),
				.q_re_out   (q_re_c[g+1]),
				.q_im_out   (q_im_c[g+1])
			);
		end
	endgenerate

	// Output stage: pick divide result or the early result; a zero divisor forces zero.
	side_t                    side_f;
	logic signed [DATA_W-1:0] fin_re, fin_im;

	assign side_f = side_c[Q_W];

	always_comb begin
		if (!side_f.is_div) begin
			fin_re = side_f.res_re;
			fin_im = side_f.res_im;
		end else if (side_f.dz) begin
			fin_re = '0;
			fin_im = '0;
		end else begin
			fin_re = div_out(side_f.neg_re, side_f.ovf_re, q_re_c[Q_W]);
			fin_im = div_out(side_f.neg_im, side_f.ovf_im, q_im_c[Q_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_c[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_re         <= fin_re;
			res_im         <= fin_im;
			operands_equal <= side_f.eq;
			divide_by_zero <= side_f.dz;
		end
	end

	// A zero divisor always yields a zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> res_re == '0 && res_im == '0)
		else $error("divide by zero with nonzero result");

	// A waiting result blocks new words.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// The zero-divisor flag only rides with divide words.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_c[0] && side_c[0].dz |-> side_c[0].is_div)
		else $error("zero divisor flagged outside divide");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the complex ALU: directed table, random words, stalls.
`timescale 1ns / 100ps

module tb_top;
	import cau_pkg::*;

	localparam logic [2:0] MODE_RSV5 = 3'd5;
	localparam logic [2:0] MODE_RSV6 = 3'd6;
	localparam logic [2:0] MODE_RSV7 = 3'd7;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam int N_RANDOM    = 880;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 60;   // a margin over the pipeline depth

	typedef struct {
		logic [2:0]        mode;
		logic signed [31:0] ar, ai, br, bi;
	} operands_t;

	typedef struct {
		logic signed [31:0] re, im;
		logic               eq, dz;
	} result_t;

	typedef struct {
		operands_t op;
		logic      typed;   // expected value given in the row itself
		result_t   res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] mode;
	logic signed [31:0] a_re, a_im, b_re, b_im;
	logic signed [31:0] res_re, res_im;
	logic operands_equal, divide_by_zero;

	result_t pending_results[$];
	result_t next_typed[$];   // typed expectations, consumed at acceptance
	logic    typed_flags[$];
	int      tx_idle_pct = 35;
	int      rx_idle_pct = 49;
	bit      hold_rx = 1'b0;
	int      errors = 0;
	int      cycles = 0;

	complex_arithmetic_unit dut (.*);

	always #4 clk = ~clk;

	// Clamp a wide signed value into the signed 32-bit range.
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sh7fff_ffff)
			return Q_MAX;
		if (v < -128'sh8000_0000)
			return Q_MIN;
		return v[31:0];
	endfunction

	// Compute the exact complex result word for one operand word.
	function automatic result_t cplx_result(input operands_t op);
		logic signed [127:0] xr, xi, yr, yi, d, nre, nim;
		result_t r;
		xr = op.ar;
		xi = op.ai;
		yr = op.br;
		yi = op.bi;
		r.re = '0;
		r.im = '0;
		r.dz = 1'b0;
		r.eq = (op.ar == op.br) && (op.ai == op.bi);
		case (op.mode)
		MODE_ADD: begin
			r.re = clamp32(xr + yr);
			r.im = clamp32(xi + yi);
		end
		MODE_SUB: begin
			r.re = clamp32(xr - yr);
			r.im = clamp32(xi - yi);
		end
		MODE_MUL: begin
			// one arithmetic shift per sum: rounds toward minus infinity
			r.re = clamp32((xr * yr - xi * yi) >>> FRAC_BITS);
			r.im = clamp32((xr * yi + xi * yr) >>> FRAC_BITS);
		end
		MODE_DIV: begin
			d = yr * yr + yi * yi;
			if (d == 0) begin
				r.dz = 1'b1;
			end else begin
				// signed division truncates toward zero
				nre = (xr * yr + xi * yi) <<< FRAC_BITS;
				nim = (xi * yr - xr * yi) <<< FRAC_BITS;
				r.re = clamp32(nre / d);
				r.im = clamp32(nim / d);
			end
		end
		MODE_NEG: begin
			r.re = clamp32(-xr);
			r.im = clamp32(-xi);
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic row_t mk(input logic [2:0] m, input logic signed [31:0] ar, ai, br, bi,
			input logic typed, input logic signed [31:0] er, ei, input logic eq, dz);
		row_t t;
		t.op = '{m, ar, ai, br, bi};
		t.typed = typed;
		t.res = '{er, ei, eq, dz};
		return t;
	endfunction

	// Mix full-range values, small values and the extremes.
	function automatic logic signed [31:0] rand_part();
		case ($urandom_range(0, 5))
		0, 1: return $urandom;
		2, 3: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
		4: begin
			case ($urandom_range(0, 4))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 0;
			3: return Q_ONE;
			default: return -1;
			endcase
		end
		default: return $signed($urandom_range(0, 2 ** 25)) - 2 ** 24;
		endcase
	endfunction

	function automatic operands_t rand_word();
		operands_t op;
		op.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		op.ar = rand_part();
		op.ai = rand_part();
		op.br = rand_part();
		op.bi = ($urandom_range(0, 4) == 0) ? 32'sd0 : rand_part();
		case ($urandom_range(0, 9))
		0: begin
			op.br = op.ar;
			op.bi = op.ai;
		end
		1: begin
			op.br = 0;
			op.bi = 0;
		end
		default: ;
		endcase
		return op;
	endfunction

	// Offer one word, idling first at the current rate; hold until accepted.
	task automatic send_word(input operands_t op, input logic typed, input result_t res);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		typed_flags.push_back(typed);
		next_typed.push_back(res);
		in_valid <= 1'b1;
		mode <= op.mode;
		a_re <= op.ar;
		a_im <= op.ai;
		b_re <= op.br;
		b_im <= op.bi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Record the expectation of every word the block takes.
	always @(posedge clk) begin
		operands_t op;
		result_t r;
		if (arst_n && in_valid && in_ready) begin
			op = '{mode, a_re, a_im, b_re, b_im};
			r = cplx_result(op);
			if (typed_flags.pop_front())
				r = next_typed.pop_front();
			else
				void'(next_typed.pop_front());
			pending_results.push_back(r);
		end
	end

	// Compare every result word with the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word re=%h im=%h", res_re, res_im);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (res_re !== e.re) begin
					$error("res_re expected %h actual %h", e.re, res_re);
					errors++;
				end
				if (res_im !== e.im) begin
					$error("res_im expected %h actual %h", e.im, res_im);
					errors++;
				end
				if (operands_equal !== e.eq) begin
					$error("operands_equal expected %b actual %b", e.eq, operands_equal);
					errors++;
				end
				if (divide_by_zero !== e.dz) begin
					$error("divide_by_zero expected %b actual %b", e.dz, divide_by_zero);
					errors++;
				end
			end
		end
	end

	// Receiver: random back-pressure, or a long hold-off on request.
	initial begin
		int held;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				held = 0;
				while (held < 150) begin
					out_ready <= 1'b0;
					@(posedge clk);
					held++;
				end
				hold_rx = 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		result_t none;
		none = '{0, 0, 1'b0, 1'b0};
		arst_n = 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_ADD;
		a_re <= 0;
		a_im <= 0;
		b_re <= 0;
		b_im <= 0;

		// mode, a, b, typed?, expected re, im, equal, divide-by-zero
		rows.push_back(mk(MODE_ADD, Q_ONE, 0, Q_ONE, 0, 1, 32'sh2_0000, 0, 1, 0));
		rows.push_back(mk(MODE_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, Q_MAX, Q_MAX, 1, 0));
		rows.push_back(mk(MODE_ADD, Q_MIN, Q_MIN, -1, Q_MIN, 1, Q_MIN, Q_MIN, 0, 0));
		rows.push_back(mk(MODE_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1, Q_MIN, Q_MAX, 0, 0));
		rows.push_back(mk(MODE_SUB, 5, 7, 5, 7, 1, 0, 0, 1, 0));
		rows.push_back(mk(MODE_MUL, 32'sh2_0000, 0, 32'sh3_0000, 0, 1, 32'sh6_0000, 0, 0, 0));
		rows.push_back(mk(MODE_MUL, -1, 0, 1, 0, 1, -1, 0, 0, 0));
		rows.push_back(mk(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1, 0, Q_MAX, 1, 0));
		rows.push_back(mk(MODE_MUL, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 0, 0, 0, 0, 0));
		rows.push_back(mk(MODE_DIV, Q_ONE, Q_ONE, 0, 0, 1, 0, 0, 0, 1));
		rows.push_back(mk(MODE_DIV, 0, 0, 0, 0, 1, 0, 0, 1, 1));
		rows.push_back(mk(MODE_DIV, Q_ONE, 0, Q_ONE, 0, 1, Q_ONE, 0, 1, 0));
		rows.push_back(mk(MODE_DIV, Q_MIN, Q_MAX, 1, 0, 1, Q_MIN, Q_MAX, 0, 0));
		rows.push_back(mk(MODE_DIV, -Q_ONE, Q_ONE, 32'sh3_0000, -7, 0, 0, 0, 0, 0));
		rows.push_back(mk(MODE_DIV, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0));
		rows.push_back(mk(MODE_NEG, Q_MIN, 1, 0, 0, 1, Q_MAX, -1, 0, 0));
		rows.push_back(mk(MODE_NEG, Q_MAX, 0, Q_MAX, 0, 1, -Q_MAX, 0, 1, 0));
		rows.push_back(mk(MODE_RSV5, 3, 4, 3, 4, 1, 0, 0, 1, 0));
		rows.push_back(mk(MODE_RSV6, 3, 4, 0, 0, 1, 0, 0, 0, 0));
		rows.push_back(mk(MODE_RSV7, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1, 0, 0, 1, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].op, rows[i].typed, rows[i].res);

		for (int n = 0; n < N_RANDOM; n++) begin
			// swap the idle rates, then run flat out
			if (n == 300) begin
				tx_idle_pct = 49;
				rx_idle_pct = 35;
			end
			if (n == 600) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_rx = 1'b1;   // fill the pipe until it stalls the input
			end
			if (n == 750) begin
				// pause until every outstanding word has drained
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			send_word(rand_word(), 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
